@@ rtl/core/bts_pkg.sv @@
package bts_pkg;

	// Fixed field widths of the sampler.
	localparam int TEXEL_BITS = 16;
	localparam int MAX_DIM    = 128;
	localparam int IDX_BITS   = 7;
	localparam int HALF_BITS  = IDX_BITS - 1;
	localparam int DIM_BITS   = 8;
	localparam int COORD_BITS = 17;
	localparam int FRAC_BITS  = 17;
	localparam int FRAC_SHIFT = 16;
	localparam int POS_BITS   = COORD_BITS + DIM_BITS;
	localparam int ROW_BITS   = TEXEL_BITS + FRAC_BITS;
	localparam int ACC_BITS   = ROW_BITS + FRAC_BITS;
	localparam int RND_SHIFT  = 2 * FRAC_SHIFT;

	typedef logic [TEXEL_BITS-1:0] texel_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [FRAC_BITS-1:0]  frac_t;
	typedef logic [DIM_BITS-1:0]   dim_t;
	typedef logic [COORD_BITS-1:0] coord_t;

	// Weight of 1.0 and half a texel in the Q.16 texel space.
	localparam frac_t ONE_Q16 = frac_t'(1 << FRAC_SHIFT);
	localparam logic [POS_BITS-1:0] HALF_Q16 = POS_BITS'(1 << (FRAC_SHIFT - 1));

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	// Control that travels with a sample down the blend pipeline.
	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	// Image sizes outside the supported range are pinned to its ends.
	function automatic dim_t clamp_dim(input logic [DIM_BITS-1:0] d);
		dim_t r;
		if (d < DIM_BITS'(2)) begin
			r = DIM_BITS'(2);
		end else if (d > DIM_BITS'(MAX_DIM)) begin
			r = DIM_BITS'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/bilinear_texel_sampler.sv @@
// Channel  | Handshake                 | Beat contents
// item     | item_valid / item_stall   | op, plane, texel_x, texel_y, texel_value, coord_u, coord_v
// result   | result_valid/result_stall | sample_value
// config   | cfg_we                    | cfg_index, cfg_data (image_width, image_height)
//
// One item is taken every cycle unless a held result beat stalls the pipeline.
// The store is four parity banks (even/odd column by even/odd row), so the four neighbors
// of a sample come from four different banks in one read cycle.
// Write beats retire in the read stage, in order with samples, so no forwarding is needed.
// Reset clears the pipeline valids and sets both image sizes to 128; the store is not cleared.
// A stalled result beat freezes the whole pipeline and raises item_stall in the same cycle.
module bilinear_texel_sampler import bts_pkg::*; #(
	parameter int PLANES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  op,
	input  logic [1:0]            plane,
	input  logic [IDX_BITS-1:0]   texel_x,
	input  logic [IDX_BITS-1:0]   texel_y,
	input  logic [TEXEL_BITS-1:0] texel_value,
	input  logic [COORD_BITS-1:0] coord_u,
	input  logic [COORD_BITS-1:0] coord_v,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [TEXEL_BITS-1:0] sample_value,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [DIM_BITS-1:0]   cfg_data
);

	localparam int HALF_DIM   = MAX_DIM / 2;
	localparam int BANK_DEPTH = PLANES * HALF_DIM * HALF_DIM;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	logic   adv;
	dim_t   width_q;
	dim_t   height_q;
	idx_t   ix_map;
	idx_t   jy_map;
	frac_t  fx_map;
	frac_t  fy_map;

	logic       v_s1;
	op_t        op_s1;
	logic       plane_ok_s1;
	logic [1:0] plane_s1;
	idx_t       wx_s1;
	idx_t       wy_s1;
	texel_t     wval_s1;
	idx_t       ix_s1;
	idx_t       jy_s1;
	frac_t      fx_s1;
	frac_t      fy_s1;

	ctl_t  ctl_s2;
	frac_t fx_s2;
	frac_t fy_s2;
	logic  i0_s2;
	logic  j0_s2;

	logic [3:0] bank_we;
	texel_t     rd [4];

	// The pipeline moves unless a finished result beat is held.
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;

	// Image size registers, clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(MAX_DIM);
			height_q <= DIM_BITS'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WIDTH:  width_q  <= clamp_dim(cfg_data);
				CFG_HEIGHT: height_q <= clamp_dim(cfg_data);
				default:    width_q  <= width_q;
			endcase
		end
	end

	// Coordinate mapping on the incoming beat.
	bts_map u_map_x (
		.coord (coord_u),
		.dim   (width_q),
		.idx   (ix_map),
		.frac  (fx_map)
	);

	bts_map u_map_y (
		.coord (coord_v),
		.dim   (height_q),
		.idx   (jy_map),
		.frac  (fy_map)
	);

	// Stage 1: mapped sample or pending write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_valid) begin
			op_s1       <= op_t'(op);
			plane_ok_s1 <= int'(plane) < PLANES;
			plane_s1    <= plane;
			wx_s1       <= texel_x;
			wy_s1       <= texel_y;
			wval_s1     <= texel_value;
			ix_s1       <= ix_map;
			jy_s1       <= jy_map;
			fx_s1       <= fx_map;
			fy_s1       <= fy_map;
		end
	end

	// Parity banks: bank {py, px} holds the texels with row parity py and column parity px.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PX = b[0];
		localparam logic PY = b[1];

		idx_t                 col;
		idx_t                 row;
		logic [BANK_AW-1:0]   raddr;
		logic [BANK_AW-1:0]   waddr;

		// Pick whichever of the two neighbors falls in this bank.
		assign col   = (ix_s1[0] == PX) ? ix_s1 : ix_s1 + IDX_BITS'(1);
		assign row   = (jy_s1[0] == PY) ? jy_s1 : jy_s1 + IDX_BITS'(1);
		assign raddr = BANK_AW'({plane_s1, row[IDX_BITS-1:1], col[IDX_BITS-1:1]});
		assign waddr = BANK_AW'({plane_s1, wy_s1[IDX_BITS-1:1], wx_s1[IDX_BITS-1:1]});

		assign bank_we[b] = adv && v_s1 && (op_s1 == OP_WRITE) && plane_ok_s1
			&& (wx_s1[0] == PX) && (wy_s1[0] == PY);

		bts_bank #(
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.en    (adv),
			.we    (bank_we[b]),
			.waddr (waddr),
			.wdata (wval_s1),
			.raddr (raddr),
			.rdata (rd[b])
		);
	end

	// Stage 2: bank data arrives; keep the weights and the bank order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2.valid <= v_s1 && (op_s1 == OP_SAMPLE);
			ctl_s2.zero  <= !plane_ok_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			i0_s2 <= ix_s1[0];
			j0_s2 <= jy_s1[0];
		end
	end

	// Blend and output register.
	bts_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.ctl          (ctl_s2),
		.t00          (rd[{j0_s2, i0_s2}]),
		.t10          (rd[{j0_s2, !i0_s2}]),
		.t01          (rd[{!j0_s2, i0_s2}]),
		.t11          (rd[{!j0_s2, !i0_s2}]),
		.fx           (fx_s2),
		.fy           (fy_s2),
		.result_valid (result_valid),
		.sample_value (sample_value)
	);

	// The left and upper neighbor indices always leave room for the right and lower ones.
	a_ix_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (op_s1 == OP_SAMPLE) |-> ({1'b0, ix_s1} + DIM_BITS'(2) <= width_q)
			&& ({1'b0, jy_s1} + DIM_BITS'(2) <= height_q))
		else $error("sample neighbor index past the image edge");

	// A full horizontal weight occurs only at the high clamp.
	a_full_frac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (op_s1 == OP_SAMPLE) && (fx_s1 == ONE_Q16)
			|-> ({1'b0, ix_s1} + DIM_BITS'(2) == width_q))
		else $error("full horizontal weight away from the edge");

	// Weights never exceed 1.0.
	a_frac_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (op_s1 == OP_SAMPLE) |-> (fx_s1 <= ONE_Q16) && (fy_s1 <= ONE_Q16))
		else $error("sample weight above one");

	// A write beat lands in exactly one bank, and only while the pipeline moves.
	a_bank_we: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we) && (!(|bank_we) || adv))
		else $error("texel write hit more than one bank or a stalled cycle");

endmodule

@@ rtl/core/bts_map.sv @@
module bts_map import bts_pkg::*; (
	input  coord_t coord,
	input  dim_t   dim,
	output idx_t   idx,
	output frac_t  frac
);

	logic [POS_BITS-1:0] prod;
	logic [POS_BITS-1:0] pos;
	logic [POS_BITS-1:0] top;

	// Texel-space position coord*dim - 0.5 and the position of the last texel center.
	assign prod = POS_BITS'(coord) * POS_BITS'(dim);
	assign pos  = prod - HALF_Q16;
	assign top  = POS_BITS'({dim - DIM_BITS'(1), FRAC_SHIFT'(0)});

	// Clamp to the edge: below the first center, or at or past the last one.
	always_comb begin
		priority if (prod <= HALF_Q16) begin
			idx  = '0;
			frac = '0;
		end else if (pos >= top) begin
			idx  = IDX_BITS'(dim - DIM_BITS'(2));
			frac = ONE_Q16;
		end else begin
			idx  = pos[FRAC_SHIFT +: IDX_BITS];
			frac = {1'b0, pos[FRAC_SHIFT-1:0]};
		end
	end

endmodule

@@ rtl/core/bts_bank.sv @@
module bts_bank import bts_pkg::*; #(
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  texel_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output texel_t                   rdata
);

	texel_t mem [DEPTH];

	// One write and one registered read per cycle; the read holds while stalled.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/bts_blend.sv @@
module bts_blend import bts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  ctl_t   ctl,
	input  texel_t t00,
	input  texel_t t10,
	input  texel_t t01,
	input  texel_t t11,
	input  frac_t  fx,
	input  frac_t  fy,
	output logic   result_valid,
	output texel_t sample_value
);

	frac_t               gx;
	frac_t               gy;
	logic [ROW_BITS-1:0] row0;
	logic [ROW_BITS-1:0] row1;
	logic [ROW_BITS-1:0] row0_s3;
	logic [ROW_BITS-1:0] row1_s3;
	frac_t               fy_s3;
	ctl_t                ctl_s3;
	logic [ACC_BITS-1:0] acc;
	logic                result_valid_q;
	texel_t              sample_q;

	// Horizontal blend of the upper and the lower pair of texels.
	assign gx   = ONE_Q16 - fx;
	assign row0 = ROW_BITS'(t00) * ROW_BITS'(gx) + ROW_BITS'(t10) * ROW_BITS'(fx);
	assign row1 = ROW_BITS'(t01) * ROW_BITS'(gx) + ROW_BITS'(t11) * ROW_BITS'(fx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row0_s3 <= row0;
			row1_s3 <= row1;
			fy_s3   <= fy;
		end
	end

	// Vertical blend, then round to nearest and drop the weight bits.
	assign gy  = ONE_Q16 - fy_s3;
	assign acc = ACC_BITS'(row0_s3) * ACC_BITS'(gy) + ACC_BITS'(row1_s3) * ACC_BITS'(fy_s3)
		+ (ACC_BITS'(1) << (RND_SHIFT - 1));

	// Output register; a sample of an absent plane reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= ctl_s3.zero ? '0 : acc[RND_SHIFT +: TEXEL_BITS];
		end
	end

	assign result_valid = result_valid_q;
	assign sample_value = sample_q;

endmodule

@@ sim/sampler_checker.sv @@
`timescale 1ns / 100ps

// Watches the item, result and register ports of the sampler, keeps its own
// copy of the texel store and image sizes, and compares every result beat with
// the blend it predicts for the oldest outstanding sample.
module sampler_checker import bts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  logic                  op,
	input  logic [1:0]            plane,
	input  logic [IDX_BITS-1:0]   texel_x,
	input  logic [IDX_BITS-1:0]   texel_y,
	input  logic [TEXEL_BITS-1:0] texel_value,
	input  logic [COORD_BITS-1:0] coord_u,
	input  logic [COORD_BITS-1:0] coord_v,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  logic [TEXEL_BITS-1:0] sample_value,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [DIM_BITS-1:0]   cfg_data,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int     REPORT_LIMIT = 10;
	localparam longint HALF_TEXEL   = 32768;
	localparam longint UNIT         = 65536;

	// Mirror of all four planes, addressed as {plane, row, column}.
	texel_t texel_mirror [0:4*MAX_DIM*MAX_DIM-1];
	dim_t   width_reg  = dim_t'(MAX_DIM);
	dim_t   height_reg = dim_t'(MAX_DIM);
	texel_t expected_samples [$];

	// Sizes outside 2..MAX_DIM act as the nearest end of that range.
	function automatic int pinned_size(input dim_t d);
		if (d < 2)
			return 2;
		if (d > MAX_DIM)
			return MAX_DIM;
		return int'(d);
	endfunction

	// Texel-space position is coord*size - 0.5 in Q.16; clamp to the edge texels.
	function automatic void locate(input coord_t c, input int size, output int base,
			output longint unsigned wt);
		longint p;
		longint top;
		p   = longint'(c) * size - HALF_TEXEL;
		top = longint'(size - 1) * UNIT;
		if (p <= 0) begin
			base = 0;
			wt   = 0;
		end else if (p >= top) begin
			base = size - 2;
			wt   = UNIT;
		end else begin
			base = int'(p >>> 16);
			wt   = p & 64'hFFFF;
		end
	endfunction

	function automatic texel_t texel_at(input logic [1:0] pl, input int x, input int y);
		return texel_mirror[{pl, idx_t'(y), idx_t'(x)}];
	endfunction

	// Exact weighted sum of the four neighbors, rounded to nearest.
	function automatic texel_t blend_sample(input logic [1:0] pl, input coord_t u,
			input coord_t v);
		int ix;
		int iy;
		longint unsigned fx, fy, gx, gy, acc;
		locate(u, pinned_size(width_reg), ix, fx);
		locate(v, pinned_size(height_reg), iy, fy);
		gx  = UNIT - fx;
		gy  = UNIT - fy;
		acc = texel_at(pl, ix, iy) * (gx * gy)
			+ texel_at(pl, ix, iy + 1) * (gx * fy)
			+ texel_at(pl, ix + 1, iy) * (fx * gy)
			+ texel_at(pl, ix + 1, iy + 1) * (fx * fy);
		acc = (acc + (64'd1 << 31)) >> 32;
		return texel_t'(acc);
	endfunction

	task automatic flag_error(input string what, input texel_t want, input texel_t got);
		if (fail_count < REPORT_LIMIT)
			$display("[%0t] %s: expected %h, got %h", $time, what, want, got);
		fail_count++;
	endtask

	// Track register writes, item beats and result beats on every edge.
	always @(posedge clk or negedge arst_n) begin
		texel_t want;
		if (!arst_n) begin
			width_reg  = dim_t'(MAX_DIM);
			height_reg = dim_t'(MAX_DIM);
			expected_samples.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end

			// Writes land in the mirror in order, so a later sample sees them.
			if (item_valid && !item_stall) begin
				if (op == OP_WRITE)
					texel_mirror[{plane, texel_y, texel_x}] = texel_value;
				else
					expected_samples.push_back(blend_sample(plane, coord_u, coord_v));
			end

			if (result_valid && !result_stall) begin
				if (expected_samples.size() == 0) begin
					flag_error("result with no sample pending", '0, sample_value);
				end else begin
					want = expected_samples.pop_front();
					if (sample_value !== want)
						flag_error("sample mismatch", want, sample_value);
				end
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import bts_pkg::*;

	localparam int MAX_GAP        = 14;
	localparam int HOLD_CYCLES    = 48;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 14;
	localparam int PHASE_ITEMS    = 22;
	localparam int SAMPLE_TRIES   = 64;
	localparam int CORNER         = 4;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	op_t                   op;
	logic [1:0]            plane;
	idx_t                  texel_x;
	idx_t                  texel_y;
	texel_t                texel_value;
	coord_t                coord_u;
	coord_t                coord_v;
	logic                  result_valid;
	logic                  result_stall;
	texel_t                sample_value;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	dim_t                  cfg_data;
	int                    fail_count;
	int                    outstanding;

	bit   burst_mode;
	bit   rx_eager;
	bit   hold_req;
	int   idle_cycles;
	dim_t image_w;
	dim_t image_h;
	dim_t phase_w [10];
	dim_t phase_h [10];
	bit   written [0:4*MAX_DIM*MAX_DIM-1];

	always #5 clk = ~clk;

	bilinear_texel_sampler uut (.*);

	sampler_checker u_chk (.*);

	// Per-beat gap on the item side; zero during back-to-back stretches.
	function automatic int draw_gap();
		return burst_mode ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic texel_t pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return texel_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly inside 0..1.0, with edges and values past 1.0 mixed in.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'($urandom_range(0, 131071));
			1: begin
				case ($urandom_range(0, 3))
					0: return coord_t'(0);
					1: return coord_t'(65536);
					2: return coord_t'(131071);
					default: return coord_t'(1);
				endcase
			end
			default: return coord_t'($urandom_range(0, 65536));
		endcase
	endfunction

	// Left or upper neighbor of a coordinate at the given image size, clamped to the edge.
	function automatic int base_index(input coord_t c, input dim_t size);
		longint p;
		longint top;
		int     s;
		s   = int'(clamp_dim(size));
		p   = longint'(c) * s - 32768;
		top = longint'(s - 1) * 65536;
		if (p <= 0)
			return 0;
		if (p >= top)
			return s - 2;
		return int'(p >>> 16);
	endfunction

	// True when all four neighbors of the sample have been written.
	function automatic bit covered(input logic [1:0] pl, input coord_t u, input coord_t v);
		int ix;
		int iy;
		ix = base_index(u, image_w);
		iy = base_index(v, image_h);
		return written[{pl, idx_t'(iy), idx_t'(ix)}]
			&& written[{pl, idx_t'(iy), idx_t'(ix + 1)}]
			&& written[{pl, idx_t'(iy + 1), idx_t'(ix)}]
			&& written[{pl, idx_t'(iy + 1), idx_t'(ix + 1)}];
	endfunction

	// Offer one item beat after the given gap and hold it until it is taken.
	task automatic send_item(input op_t o, input logic [1:0] pl, input idx_t x, input idx_t y,
			input texel_t val, input coord_t u, input coord_t v, input int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		op          <= o;
		plane       <= pl;
		texel_x     <= x;
		texel_y     <= y;
		texel_value <= val;
		coord_u     <= u;
		coord_v     <= v;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic write_texel(input logic [1:0] pl, input idx_t x, input idx_t y,
			input texel_t val, input int gap);
		written[{pl, y, x}] = 1'b1;
		send_item(OP_WRITE, pl, x, y, val, coord_t'($urandom), coord_t'($urandom), gap);
	endtask

	task automatic request_sample(input logic [1:0] pl, input coord_t u, input coord_t v,
			input int gap);
		send_item(OP_SAMPLE, pl, idx_t'($urandom), idx_t'($urandom), texel_t'($urandom),
			u, v, gap);
	endtask

	// Sample only where all four neighbors were written; fall back to the origin corner.
	task automatic random_sample(input int gap);
		logic [1:0] pl;
		coord_t     u;
		coord_t     v;
		int         n;
		pl = 2'($urandom_range(0, 3));
		u  = pick_coord();
		v  = pick_coord();
		n  = 0;
		while (!covered(pl, u, v) && n < SAMPLE_TRIES) begin
			u = pick_coord();
			v = pick_coord();
			n++;
		end
		if (!covered(pl, u, v)) begin
			u = '0;
			v = '0;
		end
		request_sample(pl, u, v, gap);
	endtask

	// Writes mostly land inside the image in use so that samples pick them up.
	task automatic random_item();
		idx_t x;
		idx_t y;
		if ($urandom_range(0, 9) < 6) begin
			random_sample(draw_gap());
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				x = idx_t'($urandom_range(0, 127));
				y = idx_t'($urandom_range(0, 127));
			end else begin
				x = idx_t'($urandom_range(0, int'(clamp_dim(image_w)) - 1));
				y = idx_t'($urandom_range(0, int'(clamp_dim(image_h)) - 1));
			end
			write_texel(2'($urandom_range(0, 3)), x, y, pick_value(), draw_gap());
		end
	endtask

	// Stop offering beats, wait for every pending sample, then let writes retire.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_image_size(input dim_t w, input dim_t h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we  <= 1'b0;
		image_w = w;
		image_h = h;
	endtask

	// Result side: random stalls per beat, plus one long hold-off on request.
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = rx_eager ? 0 : int'($urandom_range(0, MAX_GAP));
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// Ends the run when no beat or register write has moved for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int p, x, y, k, i;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		op           <= OP_WRITE;
		plane        <= '0;
		texel_x      <= '0;
		texel_y      <= '0;
		texel_value  <= '0;
		coord_u      <= '0;
		coord_v      <= '0;
		result_stall <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_WIDTH;
		cfg_data     <= '0;
		image_w      = dim_t'(MAX_DIM);
		image_h      = dim_t'(MAX_DIM);
		idle_cycles  = 0;
		phase_w = '{8'd2, 8'd128, 8'd0, 8'd255, 8'd3, 8'd1, 8'd129, 8'd16, 8'd7, 8'd128};
		phase_h = '{8'd2, 8'd128, 8'd1, 8'd0, 8'd5, 8'd255, 8'd2, 8'd128, 8'd9, 8'd4};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the corner blocks of every plane; samples only
		// touch texels that have been written.
		burst_mode = 1'b1;
		for (p = 0; p < 4; p++)
			for (y = 0; y < 2 * CORNER; y++)
				for (x = 0; x < 2 * CORNER; x++)
					write_texel(2'(p),
						idx_t'(x < CORNER ? x : MAX_DIM - 2 * CORNER + x),
						idx_t'(y < CORNER ? y : MAX_DIM - 2 * CORNER + y),
						pick_value(), 0);
		burst_mode = 1'b0;

		// Directed beats at the reset size of 128 x 128.
		// A write followed at once by a sample of the same texel center.
		write_texel(2'd0, 7'd2, 7'd2, 16'hFFFF, 0);
		request_sample(2'd0, 17'd1280, 17'd1280, 0);
		// Low edge clamp on both axes.
		write_texel(2'd1, 7'd0, 7'd0, 16'h0000, 0);
		request_sample(2'd1, 17'd0, 17'd0, 0);
		// High edge clamp on both axes.
		write_texel(2'd3, 7'd127, 7'd127, 16'hFFFF, 0);
		request_sample(2'd3, 17'd65536, 17'd65536, 0);
		// Coordinates past 1.0 and mixed edges.
		request_sample(2'd2, 17'd131071, 17'd131071, draw_gap());
		request_sample(2'd2, 17'd131071, 17'd0, draw_gap());
		request_sample(2'd2, 17'd0, 17'd65536, draw_gap());
		// Half-texel blend, position exactly zero, and both sides of the top edge.
		request_sample(2'd0, 17'd1536, 17'd1536, draw_gap());
		request_sample(2'd0, 17'd256, 17'd256, draw_gap());
		request_sample(2'd1, 17'd65280, 17'd65279, draw_gap());
		request_sample(2'd1, 17'd1, 17'd65535, draw_gap());
		// Alternating bit patterns in value, near opposite corners.
		write_texel(2'd2, 7'd126, 7'd1, 16'hAAAA, draw_gap());
		write_texel(2'd2, 7'd1, 7'd126, 16'h5555, draw_gap());
		request_sample(2'd2, 17'd65279, 17'd1024, draw_gap());

		// Random phases, each at its own image size.
		for (k = 0; k < NUM_PHASES; k++) begin
			drain_results();
			if (k < 10)
				set_image_size(phase_w[k], phase_h[k]);
			else
				set_image_size(dim_t'($urandom_range(2, 24)), dim_t'($urandom_range(2, 24)));
			burst_mode = (k % 4 == 2);
			rx_eager   = (k % 4 == 2) || (k % 4 == 3);
			// Hold the result side off while samples keep coming, to fill the pipeline.
			if (k == 5) begin
				hold_req = 1'b1;
				for (i = 0; i < 40; i++)
					random_sample(0);
			end
			for (i = 0; i < PHASE_ITEMS; i++)
				random_item();
		end

		drain_results();
		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
